/* rtl/tlf_pkg.sv */
// shared types, constants and command codes for the timed linear fader
// no dependencies; imported by every module of the fader

package tlf_pkg;

   localparam int MAX_LEVEL_DEF = 255;
   localparam int FADE_W        = 16;
   localparam int VALUE_W       = 9;
   localparam int LEVEL_OUT_W   = 8;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_SET_ABS = 2'd1;
   localparam logic [1:0] CMD_SET_REL = 2'd2;
   localparam logic [1:0] CMD_FADE    = 2'd3;

   // classified item handed from the front to the back
   typedef struct packed {
      logic                       is_tick;
      logic                       relative;
      logic [FADE_W-1:0]          dur;
      logic signed [VALUE_W-1:0]  value;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

/* rtl/timed_linear_fader.sv */
// timed linear fader top level: front stage, item queue and execution back end
// depends on tlf_pkg, tlf_front, tlf_queue and tlf_back
//
// One fader level driven by an item stream: each item is a tick or a command
// (set absolute, set relative, fade) and gives exactly one result with the
// level, a changed flag and a fading flag. The front stage and a two-entry
// queue take new items while the back end works. In the back end a command,
// a tick with no fade running and the tick that ends a fade go through the
// exec and out states; any other tick during a fade also goes through sum
// and the restoring divider, one quotient bit per cycle over the W level bits
// (8 at the default MAX_LEVEL of 255). A stalled result holds the back end.
// Levels are held at full width inside; the result carries their low 8 bits.

module timed_linear_fader
   import tlf_pkg::*;
#(
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[8:0], fade_ticks[24:9], zero fill
   input  logic [2:0]  req_tuser,   // command[1:0], is_relative[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // level[7:0]
   output logic [1:0]  rsp_tuser    // changed[0], fading[1]
);

   logic           push, pop;
   item_type       push_item, pop_item;
   queue_stat_type q_stat;

   tlf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_item  (push_item),
      .q_stat     (q_stat)
   );

   tlf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   tlf_back #(
      .MAX_LEVEL (MAX_LEVEL)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .pop_item   (pop_item),
      .q_stat     (q_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // no push into a full queue
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("queue push while full");

   // no pop from an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue pop while empty");

   // an unchanged result only comes from a tick with no fade running
   a_unchanged_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> !rsp_tuser[1])
      else $error("unchanged result while fading");

endmodule

/* rtl/tlf_front.sv */
// front end of the fader: input stage that accepts and classifies items
// depends on tlf_pkg; pushes classified items into tlf_queue

module tlf_front
   import tlf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [31:0]    req_tdata,   // value[8:0], fade_ticks[24:9], zero fill
   input  logic [2:0]     req_tuser,   // command[1:0], is_relative[2]
   output logic           push,
   output item_type       push_item,
   input  queue_stat_type q_stat
);

   logic     fr_valid_ff, fr_valid_in;
   item_type fr_item_ff, fr_item_in;
   logic     accept;

   assign push       = fr_valid_ff && !q_stat.full;
   assign req_tready = !fr_valid_ff || !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign push_item  = fr_item_ff;

   always_comb begin
      fr_item_in.value    = $signed(req_tdata[VALUE_W-1:0]);
      fr_item_in.dur      = req_tdata[VALUE_W+FADE_W-1:VALUE_W];
      fr_item_in.is_tick  = 1'b0;
      fr_item_in.relative = 1'b0;
      case (req_tuser[1:0])
         CMD_TICK: begin
            fr_item_in.is_tick = 1'b1;
            fr_item_in.dur     = '0;
         end
         CMD_SET_ABS: begin
            fr_item_in.dur = '0;
         end
         CMD_SET_REL: begin
            fr_item_in.relative = 1'b1;
            fr_item_in.dur      = '0;
         end
         CMD_FADE: begin
            fr_item_in.relative = req_tuser[2];
         end
         default: begin
            fr_item_in.is_tick = 1'b1;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         fr_valid_in = 1'b1;
      end else if (push) begin
         fr_valid_in = 1'b0;
      end else begin
         fr_valid_in = fr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_item_ff <= fr_item_in;
      end
   end

endmodule

/* rtl/tlf_queue.sv */
// short queue of classified items between the front and the back
// depends on tlf_pkg for the item type and depth

module tlf_queue
   import tlf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  item_type       push_item,
   input  logic           pop,
   output item_type       pop_item,
   output queue_stat_type q_stat
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign q_stat.full  = (count_ff == NW'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/tlf_back.sv */
// back end of the fader: level state, fade arithmetic with a serial divider
// and the result register; depends on tlf_pkg, pops items from tlf_queue

module tlf_back
   import tlf_pkg::*;
#(
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  logic           clock,
   input  logic           reset,
   output logic           pop,
   input  item_type       pop_item,
   input  queue_stat_type q_stat,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [7:0]     rsp_tdata,   // level[7:0]
   output logic [1:0]     rsp_tuser    // changed[0], fading[1]
);

   localparam int LW = $clog2(MAX_LEVEL + 1);
   localparam int NW = LW + FADE_W;
   localparam int SW = ((LW > VALUE_W) ? LW : VALUE_W) + 2;
   localparam int CW = (LW > 1) ? $clog2(LW) : 1;
   localparam int EW = FADE_W + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   localparam logic signed [SW-1:0] MAX_S = SW'(MAX_LEVEL);

   logic [2:0]              state_ff, state_in;
   item_type                op_ff, op_in;
   logic [LW-1:0]           cur_ff, cur_in, start_ff, start_in, target_ff, target_in;
   logic [FADE_W-1:0]       len_ff, len_in;
   logic [EW-1:0]           elapsed_ff, elapsed_in;
   logic                    changed_ff, changed_in;
   logic [NW-1:0]           prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [FADE_W-1:0]       rem_ff, rem_in;
   logic [LW-1:0]           quo_ff, quo_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_OUT_W-1:0]  rsp_level_ff, rsp_level_in;
   logic                    rsp_changed_ff, rsp_changed_in;
   logic                    rsp_fading_ff, rsp_fading_in;

   logic signed [SW-1:0]    base_s, sum_s;
   logic [LW-1:0]           clamped;
   logic [EW-1:0]           e_next;
   logic [FADE_W-1:0]       remain;
   logic [NW-1:0]           num;
   logic [EW-1:0]           trial, diff;
   logic                    ge;
   logic                    out_free;

   assign pop        = (state_ff == S_IDLE) && !q_stat.empty;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tuser  = {rsp_fading_ff, rsp_changed_ff};

   // clamp of absolute or relative level
   always_comb begin
      base_s = op_ff.relative ? $signed({{(SW-LW){1'b0}}, cur_ff}) : '0;
      sum_s  = base_s + {{(SW-VALUE_W){op_ff.value[VALUE_W-1]}}, op_ff.value};
      if (sum_s[SW-1]) begin
         clamped = '0;
      end else if (sum_s > MAX_S) begin
         clamped = LW'(MAX_LEVEL);
      end else begin
         clamped = LW'(sum_s);
      end
   end

   always_comb begin
      e_next = elapsed_ff + 1'b1;
      remain = len_ff - e_next[FADE_W-1:0];
      num    = prod_a_ff + prod_b_ff;
      trial  = {rem_ff, quo_ff[LW-1]};
      diff   = trial - {1'b0, len_ff};
      ge     = (trial >= {1'b0, len_ff});
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      cur_in         = cur_ff;
      start_in       = start_ff;
      target_in      = target_ff;
      len_in         = len_ff;
      elapsed_in     = elapsed_ff;
      changed_in     = changed_ff;
      prod_a_in      = prod_a_ff;
      prod_b_in      = prod_b_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_level_in   = rsp_level_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_fading_in  = rsp_fading_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               op_in    = pop_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            if (op_ff.is_tick) begin
               if (len_ff == '0) begin
                  changed_in = 1'b0;
               end else begin
                  changed_in = 1'b1;
                  elapsed_in = e_next;
                  if (e_next > {1'b0, len_ff}) begin
                     cur_in = target_ff;
                     len_in = '0;
                  end else begin
                     prod_a_in = NW'(start_ff) * NW'(remain);
                     prod_b_in = NW'(target_ff) * NW'(e_next[FADE_W-1:0]);
                     state_in  = S_SUM;
                  end
               end
            end else begin
               changed_in = 1'b1;
               len_in     = op_ff.dur;
               if (op_ff.dur != '0) begin
                  start_in   = cur_ff;
                  target_in  = clamped;
                  elapsed_in = '0;
               end else begin
                  cur_in = clamped;
               end
            end
         end
         S_SUM: begin
            rem_in   = num[NW-1:LW];
            quo_in   = num[LW-1:0];
            cnt_in   = CW'(LW - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in = ge ? diff[FADE_W-1:0] : trial[FADE_W-1:0];
            quo_in = LW'({quo_ff, ge});
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cur_in   = LW'({quo_ff, ge});
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_level_in   = LEVEL_OUT_W'(cur_ff);
               rsp_changed_in = changed_ff;
               rsp_fading_in  = (len_ff != '0);
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         start_ff     <= '0;
         target_ff    <= '0;
         len_ff       <= '0;
         elapsed_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         len_ff       <= len_in;
         elapsed_ff   <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      changed_ff     <= changed_in;
      prod_a_ff      <= prod_a_in;
      prod_b_ff      <= prod_b_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_fading_ff  <= rsp_fading_in;
   end

endmodule
